// ===== design/dua_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_pkg
// Shared types, constants and the ln fraction table for the discounted UCB1
// arm picker.
// ----------------------------------------------------------------------------
package dua_pkg;

  localparam int NumArmsDef     = 4;
  localparam int RandomArmDef   = 0;
  localparam int FallbackArmDef = 1;
  localparam int MaskArms       = 4;

  localparam int PullsW  = 15;
  localparam int RewardW = 56;
  localparam int TotalW  = 35;

  localparam int DivNumW = 88;
  localparam int DivDenW = 64;
  localparam int DivCntW = 7;
  localparam int SqrtW   = 64;
  localparam int RootW   = 32;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [31:0]        Ln2Q24      = 32'd11629080;
  localparam logic [24:0]        ExploreCQ24 = 25'd23726566;
  localparam logic [15:0]        EmaScale    = 16'd1000;
  localparam logic [1:0]         EcModeFold  = 2'd2;
  localparam logic [PullsW-1:0]  PullsMax    = '1;
  localparam logic [RewardW-1:0] RewardMax   = '1;

  typedef struct packed {
    logic [3:0]  arm;
    logic [1:0]  reason;
    logic [31:0] edge_calls;
    logic [31:0] edge_bits;
    logic [31:0] new_constants;
    logic [31:0] transition_now;
    logic [31:0] transition_start;
  } item_t;

  typedef struct packed {
    logic [3:0] next_arm;
    logic [1:0] next_reason;
    logic       recorded;
  } result_t;

  typedef enum logic [1:0] {
    RSN_UCB, RSN_RR, RSN_COLD, RSN_PLATEAU
  } reason_e;

  typedef enum logic [2:0] {
    CFG_RR_MODE, CFG_EC_MODE, CFG_TRANS_COMB, CFG_CMP_DIV,
    CFG_TRANS_DIV, CFG_EDGE_DIV, CFG_POOL_EMPTY, CFG_ELIG_MASK
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TERM, ST_TERM_W, ST_DK_RD, ST_DK_P, ST_DK_PW, ST_DK_R, ST_DK_RW,
    ST_PICK, ST_S1_RD, ST_S1_CHK, ST_S1_W, ST_LN, ST_S2_RD, ST_S2_CHK, ST_S2_MW,
    ST_S2_X, ST_S2_XW, ST_S2_Q, ST_S2_QW, ST_S2_SW, ST_S2_SC, ST_S2_FIN, ST_OUT
  } state_e;

  typedef logic [255:0][23:0] ln_tab_t;

  // shift-subtract divide, only used to build constants
  function automatic logic [63:0] udiv64_f(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(ln(1 + idx/256) * 2^24) through 2*atanh(idx/(512+idx))
  function automatic logic [23:0] ln_entry_f(input logic [7:0] idx);
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] acc;
    y    = udiv64_f({26'b0, idx, 30'b0}, 64'd512 + {56'b0, idx});
    y2   = (y * y) >> 30;
    term = y;
    acc  = '0;
    for (int j = 0; j < 32; j++) begin
      if (term != '0) begin
        acc  = acc + udiv64_f(term, 64'(2 * j + 1));
        term = (term * y2) >> 30;
      end
    end
    return 24'(((acc << 1) + 64'd32) >> 6);
  endfunction

  function automatic ln_tab_t ln_tab_build_f();
    ln_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ln_entry_f(8'(i));
    end
    return t;
  endfunction

  localparam ln_tab_t LnTab = ln_tab_build_f();
  // lnq(1000): leading one at 9, fraction bits 244
  localparam logic [31:0] Ln1000Q24 = 32'(9 * 11629080) + 32'(LnTab[244]);

endpackage

// ===== design/dua_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_div
// Restoring divider, one quotient bit per cycle. The dividend comes in
// left aligned; iters_i sets how many of its top bits are used.
// ----------------------------------------------------------------------------
module dua_div import dua_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  input  logic [DivCntW-1:0] iters_i,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o
);

  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivNumW-1:0] quot_q;
  logic [DivCntW-1:0] cnt_q;
  logic               run_q;
  logic               done_q;
  logic [DivDenW:0]   shifted;
  logic [DivDenW:0]   diff;
  logic               ge;

  assign shifted = {rem_q, num_q[DivNumW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == DivCntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= iters_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (run_q) begin
      num_q  <= num_q << 1;
      rem_q  <= ge ? diff[DivDenW-1:0] : shifted[DivDenW-1:0];
      quot_q <= {quot_q[DivNumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== design/dua_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dua_isqrt
// Integer square root, one result bit per cycle (digit-by-digit method).
// ----------------------------------------------------------------------------
module dua_isqrt import dua_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqrtW-1:0] v_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic [SqrtW-1:0] v_q;
  logic [SqrtW-1:0] res_q;
  logic [SqrtW-1:0] one_q;
  logic [5:0]       cnt_q;
  logic             run_q;
  logic             done_q;
  logic [SqrtW-1:0] trial;

  assign trial = res_q + one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 6'd1);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(SqrtW / 2);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      res_q <= '0;
      one_q <= SqrtW'(1) << (SqrtW - 2);
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + one_q;
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[RootW-1:0];

endmodule

// ===== design/discounted_ucb_arm_picker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// discounted_ucb_arm_picker
// Records the finished window of each in-range, non-plateau item into per-arm
// discounted counters and picks the next arm by empty pool, round robin,
// cold start or UCB1 score. A recorded window first runs the term divides
// and the per-arm decay; a UCB pick then runs per-arm passes through the
// bit-serial divider and square root unit.
// One item at a time: busy_o stays high until the strobe.
// The result is shown for one cycle; the receiver cannot stall it.
// Reset clears config, state, counters (via entry valid bits) and ever-picked.
// ----------------------------------------------------------------------------
module discounted_ucb_arm_picker import dua_pkg::*; #(
  parameter int NUM_ARMS     = NumArmsDef,
  parameter int RANDOM_ARM   = RandomArmDef,
  parameter int FALLBACK_ARM = FallbackArmDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  item_t               item_i,
  output logic                busy_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                res_valid_o,
  output result_t             res_o
);

  localparam int AW   = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam int EntW = PullsW + RewardW;
  localparam int SumW = PullsW + AW;
  localparam logic [AW-1:0] LastIdx = AW'(NUM_ARMS - 1);
  // ceil(2^22 / 5): exact quotient by 5 for values below 2^22
  localparam logic [19:0] Recip5 = 20'd838861;

  // configuration
  logic        rr_mode_q;
  logic [1:0]  ec_mode_q;
  logic        trans_comb_q;
  logic [15:0] cmp_div_q;
  logic [15:0] trans_div_q;
  logic [15:0] edge_div_q;
  logic        pool_empty_q;
  logic [3:0]  elig_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_mode_q    <= 1'b0;
      ec_mode_q    <= '0;
      trans_comb_q <= 1'b0;
      cmp_div_q    <= 16'd4;
      trans_div_q  <= 16'd4;
      edge_div_q   <= 16'd4;
      pool_empty_q <= 1'b0;
      elig_mask_q  <= 4'hF;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_RR_MODE:    rr_mode_q    <= cfg_wdata_i[0];
        CFG_EC_MODE:    ec_mode_q    <= cfg_wdata_i[1:0];
        CFG_TRANS_COMB: trans_comb_q <= cfg_wdata_i[0];
        CFG_CMP_DIV:    cmp_div_q    <= cfg_wdata_i;
        CFG_TRANS_DIV:  trans_div_q  <= cfg_wdata_i;
        CFG_EDGE_DIV:   edge_div_q   <= cfg_wdata_i;
        CFG_POOL_EMPTY: pool_empty_q <= cfg_wdata_i[0];
        CFG_ELIG_MASK:  elig_mask_q  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  logic [NUM_ARMS-1:0] elig;
  for (genvar g = 0; g < NUM_ARMS; g++) begin : g_elig
    if (g < MaskArms) begin : g_in
      assign elig[g] = elig_mask_q[g];
    end else begin : g_out
      assign elig[g] = 1'b0;
    end
  end

  // state and datapath registers
  state_e              state_q, state_d;
  item_t               item_q;
  logic                rec_q;
  logic [TotalW-1:0]   total_q;
  logic [1:0]          term_q;
  logic [AW-1:0]       idx_q;
  logic [PullsW-1:0]   newp_q;
  logic [SumW-1:0]     sum_q;
  logic [63:0]         norm_q;
  logic [31:0]         lnv_q;
  logic [63:0]         mean_q;
  logic [31:0]         exploit_q;
  logic [56:0]         prod_q;
  logic [31:0]         best_q;
  logic [AW-1:0]       best_arm_q;
  logic                found_q;
  logic [3:0]          nxt_arm_q;
  logic [1:0]          nxt_rsn_q;
  logic [NUM_ARMS-1:0] ever_q;
  logic                res_valid_q;
  result_t             res_q;
  logic [63:0]         dkz_q;
  logic [2:0]          dkr_q;
  logic [63:0]         dkq_q;
  logic [2:0]          dkc_q;

  // counter memory: {pulls, reward} per arm, registered read
  logic [EntW-1:0]     mem_q [NUM_ARMS];
  logic [NUM_ARMS-1:0] mvld_q;
  logic [EntW-1:0]     mrd_q;
  logic                mrv_q;
  logic                mem_we;
  logic [EntW-1:0]     mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    mrd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= '0;
      mrv_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        mvld_q[idx_q] <= 1'b1;
      end
      mrv_q <= mvld_q[idx_q];
    end
  end

  logic [EntW-1:0]    ent;
  logic [PullsW-1:0]  cur_pulls;
  logic [RewardW-1:0] cur_rew;
  logic [PullsW-1:0]  pmax;

  assign ent       = mrv_q ? mrd_q : '0;
  assign cur_pulls = ent[EntW-1 -: PullsW];
  assign cur_rew   = ent[RewardW-1:0];
  assign pmax      = (cur_pulls == '0) ? PullsW'(1) : cur_pulls;

  // shared units
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic [DivCntW-1:0] div_iters;
  logic               div_done;
  logic [DivNumW-1:0] div_quot;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [RootW-1:0]   sqrt_root;

  dua_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  dua_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .v_i     ({div_quot[39:0], 24'b0}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // divider operands
  logic [31:0] term_val;
  logic [15:0] term_den;
  logic [31:0] tdelta;
  logic [63:0] dk_src;
  logic [63:0] dk_num;
  logic [39:0] ratio_num;

  assign tdelta = (item_q.transition_now >= item_q.transition_start) ?
                  item_q.transition_now - item_q.transition_start : '0;
  assign dk_src = (state_q == ST_DK_P) ? 64'(cur_pulls) : 64'(cur_rew);
  // (950x + 500) / 1000 == (19x + 10) / 20
  assign dk_num = (dk_src << 4) + (dk_src << 1) + dk_src + 64'd10;
  assign ratio_num = 40'(lnv_q) * 40'(EmaScale);

  // decay quotient: /4 by shift, then /5 one 16-bit chunk per cycle
  logic [18:0] dk_v;
  logic [38:0] dk_prod;
  logic [15:0] dk_qc;
  logic [18:0] dk_rc;

  assign dk_v    = {dkr_q, dkz_q[63:48]};
  assign dk_prod = 39'(dk_v) * 39'(Recip5);
  assign dk_qc   = dk_prod[37:22];
  assign dk_rc   = dk_v - ({3'b0, dk_qc} << 2) - {3'b0, dk_qc};

  always_comb begin
    term_val = '0;
    term_den = 16'd1;
    unique case (term_q)
      2'd0: begin
        term_val = item_q.new_constants;
        term_den = cmp_div_q;
      end
      2'd1: begin
        term_val = trans_comb_q ? tdelta : '0;
        term_den = trans_div_q;
      end
      2'd2: begin
        term_val = (ec_mode_q == EcModeFold) ? item_q.edge_bits : '0;
        term_den = edge_div_q;
      end
      default: ;
    endcase
    if (term_den == '0) begin
      term_den = 16'd1;
    end
  end

  always_comb begin
    div_num   = '0;
    div_den   = 64'd1;
    div_iters = DivCntW'(64);
    unique case (state_q)
      ST_TERM: begin
        div_num   = {term_val, 56'b0};
        div_den   = 64'(term_den);
        div_iters = DivCntW'(32);
      end
      ST_S1_CHK, ST_S2_CHK: begin
        div_num   = {cur_rew, 8'b0, 24'b0};
        div_den   = 64'(pmax);
      end
      ST_S2_X: begin
        div_num   = {mean_q, 24'b0};
        div_den   = norm_q;
        div_iters = DivCntW'(88);
      end
      ST_S2_Q: begin
        div_num   = {ratio_num, 48'b0};
        div_den   = 64'(pmax);
        div_iters = DivCntW'(40);
      end
      default: ;
    endcase
  end

  // decay write-back with credit for the active arm
  logic [PullsW:0]  cred_p;
  logic [57:0]      cred_r;
  logic [57:0]      tot_k;
  logic             is_active;

  assign is_active = (item_q.arm == 4'(idx_q));
  assign tot_k  = (58'(total_q) << 10) - (58'(total_q) << 4) - (58'(total_q) << 3);
  assign cred_p = {1'b0, newp_q} + (PullsW + 1)'(EmaScale);
  assign cred_r = {2'b0, dkq_q[RewardW-1:0]} + tot_k;

  always_comb begin
    mem_wdata = {newp_q, dkq_q[RewardW-1:0]};
    if (is_active) begin
      mem_wdata[EntW-1 -: PullsW] = cred_p[PullsW] ? PullsMax : cred_p[PullsW-1:0];
      mem_wdata[RewardW-1:0]      = (cred_r[57:56] != '0) ? RewardMax :
                                                             cred_r[RewardW-1:0];
    end
  end

  // round robin: next eligible arm after the previous one
  logic [4:0]    rr_m;
  logic [4:0]    rr_c;
  logic [AW-1:0] rr_next;
  logic          rr_hit;

  always_comb begin
    rr_m = 5'(item_q.arm) + 5'd1;
    for (int j = 0; j < 8; j++) begin
      if (rr_m >= 5'(NUM_ARMS)) begin
        rr_m = rr_m - 5'(NUM_ARMS);
      end
    end
    rr_next = rr_m[AW-1:0];
    rr_hit  = 1'b0;
    for (int j = 0; j < NUM_ARMS; j++) begin
      rr_c = rr_m + 5'(j);
      if (rr_c >= 5'(NUM_ARMS)) begin
        rr_c = rr_c - 5'(NUM_ARMS);
      end
      if (!rr_hit && elig[rr_c[AW-1:0]]) begin
        rr_hit  = 1'b1;
        rr_next = rr_c[AW-1:0];
      end
    end
  end

  // cold start: lowest eligible arm never picked
  logic          cold_hit;
  logic [AW-1:0] cold_arm;

  always_comb begin
    cold_hit = 1'b0;
    cold_arm = '0;
    for (int i = 0; i < NUM_ARMS; i++) begin
      if (!cold_hit && elig[i] && !ever_q[i]) begin
        cold_hit = 1'b1;
        cold_arm = AW'(i);
      end
    end
  end

  // ln of the pull sum less ln(1000), zero if the sum is not above 1000
  logic [4:0]  ln_k;
  logic [7:0]  ln_f;
  logic [31:0] ln_a;
  logic [31:0] ln_v;

  always_comb begin
    ln_k = '0;
    for (int b = 0; b < SumW; b++) begin
      if (sum_q[b]) begin
        ln_k = 5'(b);
      end
    end
    ln_f = 8'(sum_q >> (ln_k - 5'd8));
    ln_a = 32'(ln_k) * Ln2Q24 + 32'(LnTab[ln_f]);
    ln_v = '0;
    if (sum_q > SumW'(EmaScale) && ln_a > Ln1000Q24) begin
      ln_v = ln_a - Ln1000Q24;
    end
  end

  // score
  logic [32:0] score_w;
  logic [31:0] score;

  assign score_w = {1'b0, exploit_q} + {1'b0, prod_q[55:24]};
  assign score   = score_w[32] ? '1 : score_w[31:0];

  logic in_range;
  assign in_range = {1'b0, item_i.arm} < 5'(NUM_ARMS);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      ever_q      <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_OUT);
      if (state_q == ST_IDLE && start_i && in_range) begin
        ever_q[item_i.arm[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    mem_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (in_range && item_i.reason != RSN_PLATEAU) ? ST_TERM : ST_PICK;
        end
      end
      ST_TERM: begin
        div_start = 1'b1;
        state_d   = ST_TERM_W;
      end
      ST_TERM_W: begin
        if (div_done) begin
          state_d = (term_q == 2'd2) ? ST_DK_RD : ST_TERM;
        end
      end
      ST_DK_RD: state_d = ST_DK_P;
      ST_DK_P: state_d = ST_DK_PW;
      ST_DK_PW: begin
        if (dkc_q == '0) begin
          state_d = ST_DK_R;
        end
      end
      ST_DK_R: state_d = ST_DK_RW;
      ST_DK_RW: begin
        if (dkc_q == '0) begin
          mem_we  = 1'b1;
          state_d = (idx_q == LastIdx) ? ST_PICK : ST_DK_RD;
        end
      end
      ST_PICK: begin
        state_d = (pool_empty_q || rr_mode_q || cold_hit) ? ST_OUT : ST_S1_RD;
      end
      ST_S1_RD: state_d = ST_S1_CHK;
      ST_S1_CHK: begin
        if (elig[idx_q] && cur_pulls != '0) begin
          div_start = 1'b1;
          state_d   = ST_S1_W;
        end else begin
          state_d = (idx_q == LastIdx) ? ST_LN : ST_S1_RD;
        end
      end
      ST_S1_W: begin
        if (div_done) begin
          state_d = (idx_q == LastIdx) ? ST_LN : ST_S1_RD;
        end
      end
      ST_LN: state_d = ST_S2_RD;
      ST_S2_RD: state_d = ST_S2_CHK;
      ST_S2_CHK: begin
        if (elig[idx_q]) begin
          div_start = 1'b1;
          state_d   = ST_S2_MW;
        end else begin
          state_d = (idx_q == LastIdx) ? ST_S2_FIN : ST_S2_RD;
        end
      end
      ST_S2_MW: begin
        if (div_done) begin
          state_d = ST_S2_X;
        end
      end
      ST_S2_X: begin
        div_start = 1'b1;
        state_d   = ST_S2_XW;
      end
      ST_S2_XW: begin
        if (div_done) begin
          state_d = ST_S2_Q;
        end
      end
      ST_S2_Q: begin
        div_start = 1'b1;
        state_d   = ST_S2_QW;
      end
      ST_S2_QW: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = ST_S2_SW;
        end
      end
      ST_S2_SW: begin
        if (sqrt_done) begin
          state_d = ST_S2_SC;
        end
      end
      ST_S2_SC: state_d = (idx_q == LastIdx) ? ST_S2_FIN : ST_S2_RD;
      ST_S2_FIN: state_d = ST_OUT;
      ST_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_q  <= item_i;
          total_q <= TotalW'(item_i.edge_calls);
          term_q  <= '0;
          idx_q   <= '0;
          rec_q   <= in_range && (item_i.reason != RSN_PLATEAU);
        end
      end
      ST_TERM_W: begin
        if (div_done) begin
          total_q <= total_q + TotalW'(div_quot[31:0]);
          term_q  <= term_q + 2'd1;
        end
      end
      ST_DK_P, ST_DK_R: begin
        dkz_q <= dk_num >> 2;
        dkr_q <= '0;
        dkq_q <= '0;
        dkc_q <= 3'd4;
      end
      ST_DK_PW: begin
        if (dkc_q != '0) begin
          dkq_q <= {dkq_q[47:0], dk_qc};
          dkr_q <= dk_rc[2:0];
          dkz_q <= dkz_q << 16;
          dkc_q <= dkc_q - 3'd1;
        end else begin
          newp_q <= dkq_q[PullsW-1:0];
        end
      end
      ST_DK_RW: begin
        if (dkc_q != '0) begin
          dkq_q <= {dkq_q[47:0], dk_qc};
          dkr_q <= dk_rc[2:0];
          dkz_q <= dkz_q << 16;
          dkc_q <= dkc_q - 3'd1;
        end else if (idx_q != LastIdx) begin
          idx_q <= idx_q + AW'(1);
        end
      end
      ST_PICK: begin
        idx_q <= '0;
        sum_q <= '0;
        norm_q <= '0;
        if (pool_empty_q) begin
          nxt_arm_q <= 4'(RANDOM_ARM);
          nxt_rsn_q <= RSN_UCB;
        end else if (rr_mode_q) begin
          nxt_arm_q <= 4'(rr_next);
          nxt_rsn_q <= RSN_RR;
        end else begin
          nxt_arm_q <= 4'(cold_arm);
          nxt_rsn_q <= RSN_COLD;
        end
      end
      ST_S1_CHK: begin
        if (elig[idx_q]) begin
          sum_q <= sum_q + SumW'(cur_pulls);
        end
        if (!(elig[idx_q] && cur_pulls != '0) && idx_q != LastIdx) begin
          idx_q <= idx_q + AW'(1);
        end
      end
      ST_S1_W: begin
        if (div_done) begin
          if (div_quot[63:0] > norm_q) begin
            norm_q <= div_quot[63:0];
          end
          if (idx_q != LastIdx) begin
            idx_q <= idx_q + AW'(1);
          end
        end
      end
      ST_LN: begin
        lnv_q   <= ln_v;
        idx_q   <= '0;
        found_q <= 1'b0;
        if (norm_q == '0) begin
          norm_q <= 64'd256;
        end
      end
      ST_S2_CHK: begin
        if (!elig[idx_q] && idx_q != LastIdx) begin
          idx_q <= idx_q + AW'(1);
        end
      end
      ST_S2_MW: begin
        if (div_done) begin
          mean_q <= div_quot[63:0];
        end
      end
      ST_S2_XW: begin
        if (div_done) begin
          exploit_q <= (div_quot[DivNumW-1:32] != '0) ? '1 : div_quot[31:0];
        end
      end
      ST_S2_SW: begin
        if (sqrt_done) begin
          prod_q <= 57'(sqrt_root) * 57'(ExploreCQ24);
        end
      end
      ST_S2_SC: begin
        if (!found_q || score > best_q) begin
          best_q     <= score;
          best_arm_q <= idx_q;
          found_q    <= 1'b1;
        end
        if (idx_q != LastIdx) begin
          idx_q <= idx_q + AW'(1);
        end
      end
      ST_S2_FIN: begin
        nxt_arm_q <= found_q ? 4'(best_arm_q) : 4'(FALLBACK_ARM);
        nxt_rsn_q <= RSN_UCB;
      end
      ST_OUT: begin
        res_q.next_arm    <= nxt_arm_q;
        res_q.next_reason <= nxt_rsn_q;
        res_q.recorded    <= rec_q;
      end
      default: ;
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
